@@ hdl/assert_macros.svh @@
// Assertion macros for the interpolating histogram binner.
// Self-contained; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define IHB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ihb assertion failed");
// The expression must never be true at a clock edge outside reset.
`define IHB_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ihb forbidden condition seen");
`else
`define IHB_ASSERT(lbl, clk, rst_n, prop)
`define IHB_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hdl/ihb_pkg.sv @@
// Shared types and constants for the interpolating histogram binner.
// No dependencies; used by ihb_ctrl, ihb_dp and the top level.
`default_nettype none

package ihb_pkg;

	// Store geometry and field widths.
	localparam int MAX_BINS    = 1024;
	localparam int ADDR_W      = $clog2(MAX_BINS);
	localparam int WEIGHT_BITS = 48;
	localparam int BINS_W      = 11;
	localparam int DATA_W      = 32;
	localparam int WQ_W        = 17;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = WEIGHT_BITS + 3 * DATA_W;

	// One unit of weight in unsigned Q1.16.
	localparam logic [WQ_W-1:0] ONE_Q16 = WQ_W'(65536);

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_X_MIN     = 2'd0;
	localparam logic [1:0] CFG_INV_WIDTH = 2'd1;
	localparam logic [1:0] CFG_BINS      = 2'd2;
	localparam logic [1:0] CFG_INTERP    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the input transfer
		logic mul;      // form the bin position, update statistics
		logic pos;      // split position into bin and fraction
		logic rd;       // read the first bin
		logic wr0;      // write the first bin, read its neighbour
		logic wr1;      // write the neighbouring bin
		logic clr_wr;   // write one zero entry of the clearing sweep
		logic out_load; // load the result register
	} ihb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_t req;
		logic interp;
		logic clr_last;
	} ihb_sts_t;

endpackage

`default_nettype wire

@@ hdl/ihb_ctrl.sv @@
// Controller state machine for the interpolating histogram binner.
// Depends on ihb_pkg for the request, command and status types.
`default_nettype none

module ihb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire ihb_pkg::req_t     in_req,
	output logic                   in_ready,
	input  wire logic              out_ready,
	output logic                   out_valid,
	input  wire ihb_pkg::ihb_sts_t sts,
	output ihb_pkg::ihb_cmd_t      cmd
);

	typedef enum logic [8:0] {
		ST_INIT = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_POS  = 9'b000001000,
		ST_RD   = 9'b000010000,
		ST_WR0  = 9'b000100000,
		ST_WR1  = 9'b001000000,
		ST_CLR  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register may be reloaded once its transfer is done.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_req)
						ihb_pkg::REQ_ADD:   state_d = ST_MUL;
						ihb_pkg::REQ_READ:  state_d = ST_RD;
						ihb_pkg::REQ_CLEAR: state_d = ST_CLR;
						default:            state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_POS;
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = (sts.req == ihb_pkg::REQ_READ) ? ST_DONE : ST_WR0;
			end
			ST_WR0: begin
				cmd.wr0 = 1'b1;
				state_d = sts.interp ? ST_WR1 : ST_DONE;
			end
			ST_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = ST_DONE;
			end
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// State register; reset starts the clearing sweep of the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ hdl/ihb_dp.sv @@
// Datapath of the interpolating histogram binner: configuration, position
// arithmetic, bin store, statistics and result register. Uses ihb_pkg.
`default_nettype none

module ihb_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [ihb_pkg::DATA_W-1:0]          cfg_data,
	input  wire ihb_pkg::req_t                       in_req,
	input  wire logic [ihb_pkg::DATA_W-1:0]          in_sample,
	input  wire logic [ihb_pkg::ADDR_W-1:0]          in_bin_index,
	input  wire ihb_pkg::ihb_cmd_t                   cmd,
	output ihb_pkg::ihb_sts_t                        sts,
	output logic [ihb_pkg::WEIGHT_BITS-1:0]          bin_weight,
	output logic [ihb_pkg::DATA_W-1:0]               sample_count,
	output logic signed [ihb_pkg::DATA_W-1:0]        running_min,
	output logic signed [ihb_pkg::DATA_W-1:0]        running_max
);

	localparam int AW = ihb_pkg::ADDR_W;
	localparam int WB = ihb_pkg::WEIGHT_BITS;
	localparam int DW = ihb_pkg::DATA_W;
	localparam int BW = ihb_pkg::BINS_W;
	localparam int QW = ihb_pkg::WQ_W;

	// Configuration registers.
	logic [DW-1:0] x_min_q;
	logic [DW-1:0] inv_width_q;
	logic [BW-1:0] bins_q;
	logic          interp_q;

	// Request capture and arithmetic stages.
	ihb_pkg::req_t        req_q;
	logic signed [DW-1:0] sample_q;
	logic [AW-1:0]        idx_q;
	logic                 rd_ok_q;
	logic [DW:0]          diff_q;
	logic [2*DW-1:0]      prod_q;
	logic                 pos_q;
	logic [AW-1:0]        n_q;
	logic [QW-1:0]        w0_q;
	logic [QW-1:0]        w1_q;

	// Statistics.
	logic [DW-1:0]        count_q;
	logic signed [DW-1:0] min_q;
	logic signed [DW-1:0] max_q;

	// Store and clearing sweep.
	logic [WB-1:0] bin_mem [ihb_pkg::MAX_BINS];
	logic [WB-1:0] rdata_q;
	logic [AW-1:0] clr_addr_q;

	// Result register.
	logic [WB-1:0]        res_weight_q;
	logic [DW-1:0]        res_count_q;
	logic signed [DW-1:0] res_min_q;
	logic signed [DW-1:0] res_max_q;

	logic [BW-1:0]   eff_bins;
	logic [BW-1:0]   last_bin;
	logic [DW-1:0]   int_part;
	logic [DW:0]     frac_rnd;
	logic [AW-1:0]   n_d;
	logic [QW-1:0]   f_d;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [WB-1:0]   mem_wdata;
	logic [WB:0]     acc_sum;
	logic [QW-1:0]   acc_w;
	logic [AW-1:0]   n_next;

	// Bins in use, held between two and the store depth.
	always_comb begin
		eff_bins = bins_q;
		if (bins_q < BW'(2)) begin
			eff_bins = BW'(2);
		end else if (bins_q > BW'(ihb_pkg::MAX_BINS)) begin
			eff_bins = BW'(ihb_pkg::MAX_BINS);
		end
	end

	assign last_bin = interp_q ? (eff_bins - BW'(2)) : (eff_bins - BW'(1));
	assign n_next   = n_q + AW'(1);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q     <= '0;
			inv_width_q <= DW'(65536);
			bins_q      <= BW'(2);
			interp_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ihb_pkg::CFG_X_MIN:     x_min_q     <= cfg_data;
				ihb_pkg::CFG_INV_WIDTH: inv_width_q <= cfg_data;
				ihb_pkg::CFG_BINS:      bins_q      <= cfg_data[BW-1:0];
				ihb_pkg::CFG_INTERP:    interp_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture the request and the exact difference to the lower edge.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= in_req;
			sample_q <= in_sample;
			idx_q    <= in_bin_index;
			rd_ok_q  <= ({1'b0, in_bin_index} < eff_bins);
			diff_q   <= {in_sample[DW-1], in_sample} - {x_min_q[DW-1], x_min_q};
		end
	end

	// Position in Q32.32; only used when the difference is positive.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= (2*DW)'(diff_q[DW-1:0]) * (2*DW)'(inv_width_q);
			pos_q  <= !diff_q[DW] && (diff_q[DW-1:0] != '0);
		end
	end

	// Bin number and rounded fraction.
	assign int_part = prod_q[2*DW-1:DW];
	assign frac_rnd = {1'b0, prod_q[DW-1:0]} + (DW+1)'(32768);

	always_comb begin
		n_d = '0;
		f_d = '0;
		if (pos_q) begin
			if (int_part > DW'(last_bin)) begin
				n_d = last_bin[AW-1:0];
				f_d = ihb_pkg::ONE_Q16;
			end else begin
				n_d = int_part[AW-1:0];
				f_d = frac_rnd[DW:DW-QW+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos) begin
			n_q  <= n_d;
			w0_q <= interp_q ? (ihb_pkg::ONE_Q16 - f_d) : ihb_pkg::ONE_Q16;
			w1_q <= f_d;
		end
	end

	// Store port control: one read and one write address per cycle.
	assign mem_re    = cmd.rd || cmd.wr0;
	assign mem_raddr = cmd.wr0 ? n_next : ((req_q == ihb_pkg::REQ_READ) ? idx_q : n_q);
	assign acc_w     = cmd.wr1 ? w1_q : w0_q;
	assign acc_sum   = {1'b0, rdata_q} + (WB+1)'(acc_w);

	always_comb begin
		mem_we    = cmd.clr_wr || cmd.wr0 || cmd.wr1;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		if (cmd.wr0 || cmd.wr1) begin
			mem_waddr = cmd.wr1 ? n_next : n_q;
			mem_wdata = acc_sum[WB] ? {WB{1'b1}} : acc_sum[WB-1:0];
		end
	end

	// Bin store.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= bin_mem[mem_raddr];
		end
	end

	// Clearing sweep address; wraps to zero after the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Sample count and running extremes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (cmd.clr_wr) begin
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (cmd.mul) begin
			if (count_q == '0) begin
				min_q <= sample_q;
				max_q <= sample_q;
			end else begin
				if (sample_q < min_q) begin
					min_q <= sample_q;
				end
				if (sample_q > max_q) begin
					max_q <= sample_q;
				end
			end
			if (count_q != {DW{1'b1}}) begin
				count_q <= count_q + DW'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_weight_q <= (req_q == ihb_pkg::REQ_READ && rd_ok_q) ? rdata_q : '0;
			res_count_q  <= count_q;
			res_min_q    <= min_q;
			res_max_q    <= max_q;
		end
	end

	assign bin_weight   = res_weight_q;
	assign sample_count = res_count_q;
	assign running_min  = res_min_q;
	assign running_max  = res_max_q;

	assign sts.req      = req_q;
	assign sts.interp   = interp_q;
	assign sts.clr_last = (clr_addr_q == AW'(ihb_pkg::MAX_BINS - 1));

endmodule

`default_nettype wire

@@ hdl/interpolating_histogram_binner.sv @@
// Interpolating histogram binner: top level joining controller and datapath.
// Depends on ihb_pkg, ihb_ctrl, ihb_dp and assert_macros.svh.
//
// Usage. Requests arrive on the s_ stream: tuser carries the kind (add,
// read, clear, no operation), tdata the sample and the bin to read. Every
// request gives exactly one result on the m_ stream with the read weight
// (zero unless a read), the sample count and the running minimum and
// maximum. Configuration is written through cfg_we/cfg_index/cfg_data while
// no request is in progress.
// Sequence after acceptance: an add passes MUL, POS, RD, WR0, then WR1 in
// interpolating mode only, then DONE (multiply, split, then a
// read-modify-write of each touched bin on the store's read and write
// ports); a read passes RD and DONE, a no-operation DONE alone, and a clear
// the sweep that zeroes the 1024 store entries one per cycle, then DONE.
// A new request is accepted in the cycle after its predecessor's result
// is loaded. Reset runs the same sweep with s_tready low; configuration
// writes are taken during it. A stalled receiver holds the result register;
// the next request is still accepted and processed and waits for the
// register to drain only when its own result is ready.
`default_nettype none
`include "assert_macros.svh"

module interpolating_histogram_binner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [ihb_pkg::DATA_W-1:0]        cfg_data,
	// Request stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [ihb_pkg::S_TDATA_W-1:0]     s_tdata,  // sample, bin_index, zero pad
	input  wire logic [1:0]                        s_tuser,  // req_type
	// Result stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [ihb_pkg::M_TDATA_W-1:0]          m_tdata   // bin_weight, sample_count,
	                                                         // running_min, running_max
);

	localparam int DW = ihb_pkg::DATA_W;
	localparam int AW = ihb_pkg::ADDR_W;

	ihb_pkg::ihb_cmd_t            cmd;
	ihb_pkg::ihb_sts_t            sts;
	ihb_pkg::req_t                req_in;
	logic [ihb_pkg::WEIGHT_BITS-1:0] bin_weight;
	logic [DW-1:0]                sample_count;
	logic signed [DW-1:0]         running_min;
	logic signed [DW-1:0]         running_max;

	assign req_in = ihb_pkg::req_t'(s_tuser);

	// Sequencing of each request.
	ihb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_req    (req_in),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic, store and statistics.
	ihb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_req       (req_in),
		.in_sample    (s_tdata[DW-1:0]),
		.in_bin_index (s_tdata[DW+AW-1:DW]),
		.cmd          (cmd),
		.sts          (sts),
		.bin_weight   (bin_weight),
		.sample_count (sample_count),
		.running_min  (running_min),
		.running_max  (running_max)
	);

	assign m_tdata = {running_max, running_min, sample_count, bin_weight};

	// Only one request is in progress: acceptance makes the block busy.
	`IHB_ASSERT(a_busy_after_accept, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)

	// Loading the result register always presents a result.
	`IHB_ASSERT(a_load_shows_result, clk, arst_n, cmd.out_load |=> m_tvalid)

	// A zero count only follows reset or clear, where the extremes are zero.
	`IHB_ASSERT_NEVER(a_empty_extremes, clk, arst_n,
		m_tvalid && (sample_count == '0) && ((running_min != '0) || (running_max != '0)))

endmodule

`default_nettype wire
